// ===== src/coordinate_triple_text_parser_assert.svh =====
// Assertion macros used by the ctpp_back module of the coordinate triple text parser.
`ifndef COORDINATE_TRIPLE_TEXT_PARSER_ASSERT_SVH
`define COORDINATE_TRIPLE_TEXT_PARSER_ASSERT_SVH
`ifndef SYNTH
`define CTPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("ctpp assertion failed");
`define CTPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("ctpp assertion failed");
`else
`define CTPP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define CTPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/ctpp_pkg.sv =====
// Types, constants and tables of the coordinate triple text parser.
package ctpp_pkg;

	localparam int FRACTION_DIGITS    = 6;
	localparam int MAX_INTEGER_DIGITS = 18;

	localparam int CHAR_W   = 8;
	localparam int STATUS_W = 3;
	localparam int VALUE_W  = 46;
	localparam int INT_W    = 26;
	localparam int FRAC_W   = 30;
	localparam int ICNT_W   = 5;
	localparam int FCNT_W   = 4;
	localparam int HLIM_W   = 25;
	localparam int VLIM_W   = 26;
	localparam int PROD_W   = INT_W + FRAC_W;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [INT_W-1:0] ACC_MAX = '1;

	localparam logic [FRAC_W-1:0] POW10 [0:9] = '{
		30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
		30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
	};
	localparam logic [FRAC_W-1:0] SCALE = POW10[FRACTION_DIGITS];

	localparam logic [HLIM_W-1:0] HLIM_RESET = 25'd32000000;
	localparam logic [VLIM_W-1:0] VMIN_RESET = 26'd1;
	localparam logic [VLIM_W-1:0] VMAX_RESET = 26'd254;

	typedef enum logic [1:0] {
		REG_HLIMIT = 2'd0,
		REG_VMIN   = 2'd1,
		REG_VMAX   = 2'd2
	} ctpp_reg_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_FIRST_MISSING = 3'd1,
		ST_LATER_MISSING = 3'd2,
		ST_NO_SEP        = 3'd3,
		ST_EXTRA         = 3'd4,
		ST_XZ_RANGE      = 3'd5,
		ST_Y_RANGE       = 3'd6
	} ctpp_status_t;

	typedef enum logic [2:0] {
		CH_SPACE,
		CH_DIGIT,
		CH_SIGN,
		CH_POINT,
		CH_COMMA,
		CH_END,
		CH_OTHER
	} ctpp_class_t;

	typedef enum logic [3:0] {
		PH_LEAD,
		PH_SIGN,
		PH_NEED,
		PH_INT,
		PH_FRAC_NEED,
		PH_FRAC,
		PH_AFTER,
		PH_SEP_PRE,
		PH_SEP_POST,
		PH_ERROR
	} ctpp_phase_t;

	typedef struct packed {
		ctpp_class_t cls;
		logic [3:0]  digit;
		logic        minus;
	} ctpp_item_t;

	typedef struct packed {
		logic              neg;
		logic [INT_W-1:0]  mag_int;
		logic [FRAC_W-1:0] frac;
	} ctpp_num_t;

	typedef struct packed {
		ctpp_status_t    status;
		ctpp_num_t [2:0] nums;
	} ctpp_result_t;

	typedef struct packed {
		logic        [HLIM_W-1:0] hlimit;
		logic signed [VLIM_W-1:0] vmin;
		logic signed [VLIM_W-1:0] vmax;
	} ctpp_limits_t;

endpackage

// ===== src/ctpp_channels.sv =====
// Handshake channel interfaces for characters in and coordinate results out.
interface ctpp_char_if;
	import ctpp_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_code;
	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface ctpp_coord_if;
	import ctpp_pkg::*;
	logic                       valid;
	logic                       ready;
	logic        [STATUS_W-1:0] status;
	logic signed [VALUE_W-1:0]  x_value;
	logic signed [VALUE_W-1:0]  y_value;
	logic signed [VALUE_W-1:0]  z_value;
	modport source (output valid, output status, output x_value, output y_value,
		output z_value, input ready);
	modport sink (input valid, input status, input x_value, input y_value,
		input z_value, output ready);
endinterface

// ===== src/ctpp_front.sv =====
// Character classifier and the item queue that feeds the parser.
module ctpp_front (
	input  logic                clk,
	input  logic                arst_n,
	ctpp_char_if.sink           chars,
	output logic                item_valid,
	output ctpp_pkg::ctpp_item_t item,
	input  logic                item_ready
);
	import ctpp_pkg::*;

	ctpp_item_t          queue_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	ctpp_item_t          cls_item;
	logic                push;
	logic                pop;

	always_comb begin
		cls_item.digit = 4'(chars.char_code - 8'h30);
		cls_item.minus = (chars.char_code == 8'h2D);
		if (chars.char_code == 8'h20 || chars.char_code == 8'h09 ||
			chars.char_code == 8'h0A || chars.char_code == 8'h0D) begin
			cls_item.cls = CH_SPACE;
		end else if (chars.char_code >= 8'h30 && chars.char_code <= 8'h39) begin
			cls_item.cls = CH_DIGIT;
		end else if (chars.char_code == 8'h2B || chars.char_code == 8'h2D) begin
			cls_item.cls = CH_SIGN;
		end else if (chars.char_code == 8'h2E) begin
			cls_item.cls = CH_POINT;
		end else if (chars.char_code == 8'h2C) begin
			cls_item.cls = CH_COMMA;
		end else if (chars.char_code == 8'h00) begin
			cls_item.cls = CH_END;
		end else begin
			cls_item.cls = CH_OTHER;
		end
	end

	assign chars.ready = (count_q != QCNT_W'(QDEPTH));
	assign push        = chars.valid && chars.ready;
	assign item_valid  = (count_q != '0);
	assign pop         = item_valid && item_ready;
	assign item        = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cls_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

// ===== src/ctpp_back.sv =====
// Parser state machine that turns classified items into number parts and status.
`include "coordinate_triple_text_parser_assert.svh"
module ctpp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  ctpp_pkg::ctpp_item_t  item,
	output logic                  item_ready,
	input  ctpp_pkg::ctpp_limits_t limits,
	output logic                  emit,
	output ctpp_pkg::ctpp_result_t result,
	input  logic                  res_ready
);
	import ctpp_pkg::*;

	ctpp_phase_t       phase_q, phase_d;
	logic [1:0]        idx_q, idx_d;
	ctpp_status_t      err_q, err_d;
	logic              neg_q, neg_d;
	logic [INT_W-1:0]  int_q, int_d;
	logic              big_q, big_d;
	logic [ICNT_W-1:0] icnt_q, icnt_d;
	logic [FRAC_W-1:0] frac_q, frac_d;
	logic [FCNT_W-1:0] fcnt_q, fcnt_d;
	ctpp_num_t         x_q, x_d, y_q, y_d;
	logic [1:0]        rf_q, rf_d;
	logic              step;

	assign item_ready = (item.cls != CH_END) || res_ready;
	assign step       = item_valid && item_ready;

	always_comb begin
		logic [FRAC_W-1:0]      nxt;
		logic signed [INT_W:0]  ls;
		logic signed [INT_W:0]  vmin_x;
		logic signed [INT_W:0]  vmax_x;
		logic                   fz;
		logic                   lo_fail;
		logic                   hi_fail;
		logic                   finish;
		ctpp_status_t           miss;
		ctpp_num_t              cur;
		phase_d = phase_q;
		idx_d   = idx_q;
		err_d   = err_q;
		neg_d   = neg_q;
		int_d   = int_q;
		big_d   = big_q;
		icnt_d  = icnt_q;
		frac_d  = frac_q;
		fcnt_d  = fcnt_q;
		x_d     = x_q;
		y_d     = y_q;
		rf_d    = rf_q;
		finish  = 1'b0;
		nxt     = '0;
		miss    = (idx_q == 2'd0) ? ST_FIRST_MISSING : ST_LATER_MISSING;
		emit    = 1'b0;
		result  = '0;

		if (phase_d == PH_LEAD && item.cls != CH_SPACE) begin
			phase_d = PH_SIGN;
		end
		if (phase_d == PH_SEP_PRE && item.cls != CH_SPACE && item.cls != CH_COMMA &&
			idx_d != 2'd3) begin
			phase_d = PH_SIGN;
		end
		if (phase_d == PH_SEP_POST && item.cls != CH_SPACE && idx_d != 2'd3) begin
			phase_d = PH_SIGN;
		end

		if (phase_d == PH_SIGN) begin
			neg_d  = 1'b0;
			int_d  = '0;
			big_d  = 1'b0;
			icnt_d = '0;
			frac_d = '0;
			fcnt_d = '0;
		end

		case (phase_d)
			PH_SIGN: begin
				if (item.cls == CH_SIGN) begin
					neg_d   = item.minus;
					phase_d = PH_NEED;
				end else if (item.cls == CH_DIGIT) begin
					phase_d = PH_INT;
				end else begin
					if (err_d == ST_OK) err_d = miss;
					phase_d = PH_ERROR;
				end
			end
			PH_NEED: begin
				if (item.cls == CH_DIGIT) begin
					phase_d = PH_INT;
				end else begin
					if (err_d == ST_OK) err_d = miss;
					phase_d = PH_ERROR;
				end
			end
			PH_INT: begin
				if (item.cls == CH_POINT) begin
					phase_d = PH_FRAC_NEED;
				end else if (item.cls != CH_DIGIT) begin
					finish = 1'b1;
				end
			end
			PH_FRAC_NEED: begin
				if (item.cls == CH_DIGIT) begin
					phase_d = PH_FRAC;
				end else begin
					if (err_d == ST_OK) err_d = miss;
					phase_d = PH_ERROR;
				end
			end
			PH_FRAC: begin
				if (item.cls != CH_DIGIT) begin
					finish = 1'b1;
				end
			end
			PH_SEP_PRE: begin
				if (item.cls == CH_COMMA) begin
					phase_d = PH_SEP_POST;
				end else if (item.cls != CH_SPACE && item.cls != CH_END) begin
					if (err_d == ST_OK) err_d = ST_EXTRA;
					phase_d = PH_ERROR;
				end
			end
			PH_SEP_POST: begin
				if (item.cls != CH_SPACE) begin
					if (err_d == ST_OK) err_d = ST_EXTRA;
					phase_d = PH_ERROR;
				end
			end
			default: begin
			end
		endcase

		if (item.cls == CH_DIGIT && phase_d == PH_INT) begin
			icnt_d = icnt_d + 1'b1;
			if (icnt_d > ICNT_W'(MAX_INTEGER_DIGITS)) begin
				if (err_d == ST_OK) err_d = miss;
				phase_d = PH_ERROR;
			end else if (!big_d) begin
				nxt = FRAC_W'(int_d) * FRAC_W'(10) + FRAC_W'(item.digit);
				if (nxt > FRAC_W'(ACC_MAX)) begin
					big_d = 1'b1;
				end else begin
					int_d = INT_W'(nxt);
				end
			end
		end
		if (item.cls == CH_DIGIT && phase_d == PH_FRAC &&
			fcnt_d < FCNT_W'(FRACTION_DIGITS)) begin
			frac_d = frac_d + FRAC_W'(FRAC_W'(item.digit) *
				POW10[FCNT_W'(FRACTION_DIGITS - 1) - fcnt_d]);
			fcnt_d = fcnt_d + 1'b1;
		end

		fz      = (frac_d != '0);
		ls      = neg_d ? -$signed({1'b0, int_d}) : $signed({1'b0, int_d});
		vmin_x  = (INT_W+1)'(limits.vmin);
		vmax_x  = (INT_W+1)'(limits.vmax);
		lo_fail = (neg_d && fz) ? (ls <= vmin_x) : (ls < vmin_x);
		hi_fail = (!neg_d && fz) ? (ls >= vmax_x) : (ls > vmax_x);
		cur     = '{neg: neg_d, mag_int: int_d, frac: frac_d};

		if (finish) begin
			if (idx_d == 2'd1) begin
				if (big_d || lo_fail || hi_fail) rf_d[1] = 1'b1;
			end else begin
				if (big_d || int_d > INT_W'(limits.hlimit) ||
					(int_d == INT_W'(limits.hlimit) && fz)) begin
					rf_d[0] = 1'b1;
				end
			end
			if (idx_d == 2'd0) x_d = cur;
			if (idx_d == 2'd1) y_d = cur;
			if (idx_d != 2'd3) idx_d = idx_d + 1'b1;
			phase_d = PH_AFTER;
		end

		if (phase_d == PH_AFTER) begin
			if (item.cls == CH_SPACE) begin
				phase_d = PH_SEP_PRE;
			end else if (item.cls == CH_COMMA) begin
				phase_d = PH_SEP_POST;
			end else if (idx_d != 2'd3) begin
				if (err_d == ST_OK) err_d = ST_NO_SEP;
				phase_d = PH_ERROR;
			end else if (item.cls != CH_END) begin
				if (err_d == ST_OK) err_d = ST_EXTRA;
				phase_d = PH_ERROR;
			end
		end

		if (item.cls == CH_END) begin
			emit          = step;
			result.status = err_d;
			if (err_d == ST_OK && rf_d[0]) begin
				result.status = ST_XZ_RANGE;
			end else if (err_d == ST_OK && rf_d[1]) begin
				result.status = ST_Y_RANGE;
			end
			result.nums[0] = x_d;
			result.nums[1] = y_d;
			result.nums[2] = cur;
			phase_d = PH_LEAD;
			idx_d   = '0;
			err_d   = ST_OK;
			neg_d   = 1'b0;
			int_d   = '0;
			big_d   = 1'b0;
			icnt_d  = '0;
			frac_d  = '0;
			fcnt_d  = '0;
			x_d     = '0;
			y_d     = '0;
			rf_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			idx_q   <= '0;
			err_q   <= ST_OK;
			neg_q   <= 1'b0;
			int_q   <= '0;
			big_q   <= 1'b0;
			icnt_q  <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			rf_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			err_q   <= err_d;
			neg_q   <= neg_d;
			int_q   <= int_d;
			big_q   <= big_d;
			icnt_q  <= icnt_d;
			frac_q  <= frac_d;
			fcnt_q  <= fcnt_d;
			x_q     <= x_d;
			y_q     <= y_d;
			rf_q    <= rf_d;
		end
	end

	`CTPP_ASSERT_NOW(a_error_parks, clk, arst_n, err_q != ST_OK, phase_q == PH_ERROR)
	`CTPP_ASSERT_NEXT(a_end_restarts, clk, arst_n, emit, phase_q == PH_LEAD && idx_q == 2'd0)
	`CTPP_ASSERT_NOW(a_emit_has_room, clk, arst_n, emit, res_ready && item.cls == CH_END)
endmodule

// ===== src/ctpp_result.sv =====
// Result pipeline: scales number parts to fixed point and holds the output item.
module ctpp_result (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   emit,
	input  ctpp_pkg::ctpp_result_t result,
	output logic                   res_ready,
	ctpp_coord_if.source           coords
);
	import ctpp_pkg::*;

	logic                     v_s1;
	ctpp_status_t             status_s1;
	logic [2:0]               neg_s1;
	logic [VALUE_W-1:0]       prod_s1 [3];
	logic [FRAC_W-1:0]        frac_s1 [3];
	logic                     v_s2;
	ctpp_status_t             status_s2;
	logic signed [VALUE_W-1:0] val_s2 [3];
	logic                     adv2;
	logic                     adv1;

	assign adv2      = !v_s2 || coords.ready;
	assign adv1      = v_s1 && adv2;
	assign res_ready = !v_s1 || adv2;

	always_ff @(posedge clk) begin
		if (emit && res_ready) begin
			status_s1 <= result.status;
			for (int k = 0; k < 3; k++) begin
				neg_s1[k]  <= result.nums[k].neg;
				prod_s1[k] <= VALUE_W'(PROD_W'(result.nums[k].mag_int) * PROD_W'(SCALE));
				frac_s1[k] <= result.nums[k].frac;
			end
		end
		if (adv1) begin
			status_s2 <= status_s1;
			for (int k = 0; k < 3; k++) begin
				if (status_s1 != ST_OK) begin
					val_s2[k] <= '0;
				end else if (neg_s1[k]) begin
					val_s2[k] <= -$signed(prod_s1[k] + VALUE_W'(frac_s1[k]));
				end else begin
					val_s2[k] <= $signed(prod_s1[k] + VALUE_W'(frac_s1[k]));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (res_ready) begin
				v_s1 <= emit;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	assign coords.valid   = v_s2;
	assign coords.status  = status_s2;
	assign coords.x_value = val_s2[0];
	assign coords.y_value = val_s2[1];
	assign coords.z_value = val_s2[2];
endmodule

// ===== src/coordinate_triple_text_parser.sv =====
// Top level of the coordinate triple text parser with its register port.
//  channel  | dir | handshake     | payload
//  chars    | in  | valid / ready | char_code[7:0]
//  coords   | out | valid / ready | status[2:0], x_value, y_value, z_value[45:0]
//  apb      | in  | psel/penable  | paddr[3:0], pwdata/prdata[31:0]
// One character is taken every cycle while the four-entry item queue has room.
// The parser consumes one queued item per cycle unless a terminator must wait;
// a result passes from its terminating character through the item queue and the
// two-stage scaling multiplier pipeline. A waiting result stalls only terminators.
// Reset clears all control state at once; there is no clearing pass.
module coordinate_triple_text_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	ctpp_char_if.sink                     chars,
	ctpp_coord_if.source                  coords,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ctpp_pkg::PADDR_W-1:0]  paddr,
	input  logic [ctpp_pkg::PDATA_W-1:0]  pwdata,
	output logic [ctpp_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import ctpp_pkg::*;

	ctpp_limits_t limits_q;
	logic         item_valid;
	ctpp_item_t   item;
	logic         item_ready;
	logic         emit;
	ctpp_result_t result;
	logic         res_ready;
	logic         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.hlimit <= HLIM_RESET;
			limits_q.vmin   <= VMIN_RESET;
			limits_q.vmax   <= VMAX_RESET;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_HLIMIT: limits_q.hlimit <= pwdata[HLIM_W-1:0];
				REG_VMIN:   limits_q.vmin   <= pwdata[VLIM_W-1:0];
				REG_VMAX:   limits_q.vmax   <= pwdata[VLIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HLIMIT: prdata = PDATA_W'(limits_q.hlimit);
			REG_VMIN:   prdata = PDATA_W'(limits_q.vmin);
			REG_VMAX:   prdata = PDATA_W'(limits_q.vmax);
			default:    prdata = '0;
		endcase
	end

	ctpp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (chars),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	ctpp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.limits     (limits_q),
		.emit       (emit),
		.result     (result),
		.res_ready  (res_ready)
	);

	ctpp_result u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.emit      (emit),
		.result    (result),
		.res_ready (res_ready),
		.coords    (coords)
	);
endmodule
